/* rtl/bmh_pkg.sv */
// Shared types and constants for the binary max-heap priority queue.
// Holds the item structs, the token control struct and the operation,
// token-kind and error codes. Depends on nothing.
`default_nettype none

package bmh_pkg;

    // Fixed widths of the item fields
    localparam int KEY_IN_W = 32;
    localparam int TOP_W    = 32;
    localparam int TOTAL_W  = 9;
    localparam int ERR_W    = 2;

    // Defaults for the top-level parameters
    localparam int CAPACITY_DEF  = 256;
    localparam int KEY_WIDTH_DEF = 32;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

    // Token kinds walking down the level chain
    localparam logic KIND_INS  = 1'b0;
    localparam logic KIND_DOWN = 1'b1;

    typedef struct packed {
        logic                op;
        logic [KEY_IN_W-1:0] key_value;
    } t_in_item;

    typedef struct packed {
        logic [TOP_W-1:0]   top_value;
        logic               top_valid;
        logic [TOTAL_W-1:0] element_total;
        logic [ERR_W-1:0]   error_code;
    } t_out_item;

    typedef struct packed {
        logic vld;
        logic kind;
    } t_tok_ctl;

endpackage

`default_nettype wire

/* rtl/bmh_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/bmh_cell.sv */
// One tree level of the heap: a pair of RAMs (left and right children) and
// the compare/swap step for tokens passing through. Uses bmh_pkg and bmh_ram.
`default_nettype none

module bmh_cell import bmh_pkg::*; #(
    parameter int LEVEL  = 1,
    parameter int LEVELS = 2,
    parameter int KW     = 32,
    parameter int PW     = 9,
    parameter int SW     = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // token from the level above
    input  wire t_tok_ctl      i_tok,
    input  wire logic [PW-1:0] i_pos,
    input  wire logic [PW-1:0] i_tgt,
    input  wire logic [SW-1:0] i_sh,
    input  wire logic [KW-1:0] i_key,
    // token to the level below
    output t_tok_ctl           o_tok,
    output logic      [PW-1:0] o_pos,
    output logic      [PW-1:0] o_tgt,
    output logic      [SW-1:0] o_sh,
    output logic      [KW-1:0] o_key,
    // promoted key written into this level by the level below
    input  wire logic          i_up_vld,
    input  wire logic [PW-1:0] i_up_pos,
    input  wire logic [KW-1:0] i_up_key,
    // promoted key for the level above
    output logic               o_up_vld,
    output logic      [PW-1:0] o_up_pos,
    output logic      [KW-1:0] o_up_key,
    // read of the last key
    input  wire logic          i_fetch_vld,
    input  wire logic [PW-1:0] i_fetch_pos,
    output logic      [KW-1:0] o_fetch_key,
    output logic               o_done
);

    localparam int AW    = (LEVEL > 1) ? LEVEL - 1 : 1;
    localparam int DEPTH = 1 << (LEVEL - 1);
    localparam bit LAST  = (LEVEL == LEVELS - 1);

    logic          r_vld;
    logic          r_kind;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_tgt;
    logic [SW-1:0] r_sh;
    logic [KW-1:0] r_key;
    logic          r_fhit;
    logic          r_fhalf;

    t_tok_ctl      r_otok;
    logic [PW-1:0] r_opos;
    logic [PW-1:0] r_otgt;
    logic [SW-1:0] r_osh;
    logic [KW-1:0] r_okey;
    logic          r_up_vld;
    logic [PW-1:0] r_up_pos;
    logic [KW-1:0] r_up_key;
    logic          r_done;

    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_row_own;
    logic [AW-1:0] w_row_up;
    logic [KW-1:0] w_wdata;
    logic          w_we0;
    logic          w_we1;
    logic [KW-1:0] w_rd0;
    logic [KW-1:0] w_rd1;
    logic          w_hit;

    logic          w_ib;
    logic          w_last;
    logic [KW-1:0] w_iv;
    logic          w_iswap;
    logic [PW-1:0] w_c1;
    logic          w_ex1;
    logic          w_pick;
    logic [KW-1:0] w_dv;
    logic          w_dswap;
    logic [PW-1:0] w_dc;
    logic          w_dmore;

    logic          n_wr;
    logic          n_half;
    logic          n_fwd;
    logic          n_up;
    logic [PW-1:0] n_pos;
    logic [SW-1:0] n_sh;
    logic [KW-1:0] n_key;

    // A token addresses the row of its parent; a node is found by its parent.
    assign w_raddr   = i_tok.vld ? ((LEVEL > 1) ? AW'(i_pos) : AW'(0))
                                 : ((LEVEL > 1) ? AW'(i_fetch_pos >> 1) : AW'(0));
    assign w_row_own = (LEVEL > 1) ? AW'(r_pos) : AW'(0);
    assign w_row_up  = (LEVEL > 1) ? AW'(i_up_pos >> 1) : AW'(0);
    assign w_hit     = i_fetch_vld && ((i_fetch_pos >> LEVEL) == PW'(1));

    // insert step: follow the path to the new slot
    assign w_ib    = r_tgt[r_sh];
    assign w_last  = (r_sh == '0);
    assign w_iv    = w_ib ? w_rd1 : w_rd0;
    assign w_iswap = (w_iv < r_key);

    // sift-down step: larger child, left wins a tie
    assign w_c1    = {r_pos[PW-2:0], 1'b1};
    assign w_ex1   = (w_c1 <= r_tgt);
    assign w_pick  = w_ex1 && (w_rd0 < w_rd1);
    assign w_dv    = w_pick ? w_rd1 : w_rd0;
    assign w_dswap = (r_key < w_dv);
    assign w_dc    = {r_pos[PW-2:0], w_pick};
    assign w_dmore = ({w_dc, 1'b0} <= {1'b0, r_tgt});

    always_comb begin
        n_wr   = 1'b0;
        n_half = 1'b0;
        n_fwd  = 1'b0;
        n_up   = 1'b0;
        n_pos  = {r_pos[PW-2:0], w_ib};
        n_sh   = r_sh - SW'(1);
        n_key  = r_key;
        if (r_vld) begin
            if (r_kind == KIND_INS) begin
                n_wr   = w_last || w_iswap;
                n_half = w_ib;
                n_fwd  = !w_last && !LAST;
                n_key  = w_iswap ? w_iv : r_key;
            end else begin
                n_wr   = w_dswap;
                n_half = w_pick;
                n_up   = w_dswap;
                n_fwd  = w_dswap && w_dmore && !LAST;
                n_pos  = w_dc;
            end
        end
    end

    // own write and promoted write never fall in the same cycle
    assign w_we0   = (n_wr && !n_half) || (i_up_vld && !i_up_pos[0]);
    assign w_we1   = (n_wr && n_half) || (i_up_vld && i_up_pos[0]);
    assign w_waddr = n_wr ? w_row_own : w_row_up;
    assign w_wdata = n_wr ? r_key : i_up_key;

    bmh_ram #(.WIDTH(KW), .DEPTH(DEPTH), .AW(AW)) u_ram_left (
        .i_clk   (i_clk),
        .i_we    (w_we0),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd0)
    );

    bmh_ram #(.WIDTH(KW), .DEPTH(DEPTH), .AW(AW)) u_ram_right (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_fhit   <= 1'b0;
            r_otok   <= '0;
            r_up_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_vld       <= i_tok.vld;
            r_fhit      <= w_hit;
            r_otok.vld  <= n_fwd;
            r_otok.kind <= r_kind;
            r_up_vld    <= n_up;
            r_done      <= r_vld && !n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= i_tok.kind;
        r_pos    <= i_pos;
        r_tgt    <= i_tgt;
        r_sh     <= i_sh;
        r_key    <= i_key;
        r_fhalf  <= i_fetch_pos[0];
        r_opos   <= n_pos;
        r_otgt   <= r_tgt;
        r_osh    <= n_sh;
        r_okey   <= n_key;
        r_up_pos <= r_pos;
        r_up_key <= w_dv;
    end

    assign o_tok       = r_otok;
    assign o_pos       = r_opos;
    assign o_tgt       = r_otgt;
    assign o_sh        = r_osh;
    assign o_key       = r_okey;
    assign o_up_vld    = r_up_vld;
    assign o_up_pos    = r_up_pos;
    assign o_up_key    = r_up_key;
    assign o_done      = r_done;
    assign o_fetch_key = r_fhit ? (r_fhalf ? w_rd1 : w_rd0) : '0;

endmodule

`default_nettype wire

/* rtl/binary_max_heap_priority_queue.sv */
// Top level of the binary max-heap priority queue: root register, control
// sequencer and the chain of level cells. Uses bmh_pkg and bmh_cell.
//
//   channel | direction | payload     | handshake
//   --------+-----------+-------------+--------------------------------
//   in      | into      | t_in_item   | i_in_valid / o_in_stall
//   out     | out of    | t_out_item  | o_out_valid / i_out_stall
//
// One item is worked on at a time. A token walks down the level cells; at
// each level it takes a registered RAM read, then a compare and write. A
// removal first reads the last key into the root, then sifts it down; a
// removal that leaves one key needs no sift. Full, empty and single-key
// cases skip the level chain. The next item is taken as soon as the result
// is loaded into the output register, even while it is stalled.
// Reset clears the count and all control; the key RAMs are not cleared.
`default_nettype none

module binary_max_heap_priority_queue import bmh_pkg::*; #(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    localparam int PW     = $clog2(CAPACITY + 1);
    localparam int LEVELS = PW;
    localparam int SW     = $clog2(PW);
    localparam int KW     = KEY_WIDTH;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // control registers
    logic [2:0]     r_state, n_state;
    logic [PW-1:0]  r_count, n_count;
    logic           r_out_vld, n_out_vld;
    t_tok_ctl       r_t1, n_t1;
    logic           r_fetch_vld, n_fetch_vld;

    // payload registers
    logic [KW-1:0]    r_root, n_root;
    logic [ERR_W-1:0] r_err, n_err;
    logic [PW-1:0]    r_t1_pos, n_t1_pos;
    logic [PW-1:0]    r_t1_tgt, n_t1_tgt;
    logic [SW-1:0]    r_t1_sh, n_t1_sh;
    logic [KW-1:0]    r_t1_key, n_t1_key;
    logic [PW-1:0]    r_fetch_pos, n_fetch_pos;
    t_out_item        r_out, n_out;

    // level chain
    t_tok_ctl      w_tok [1:LEVELS-1];
    logic [PW-1:0] w_pos [1:LEVELS-1];
    logic [PW-1:0] w_tgt [1:LEVELS-1];
    logic [SW-1:0] w_sh  [1:LEVELS-1];
    logic [KW-1:0] w_tkey [1:LEVELS-1];
    logic          w_up_vld [1:LEVELS];
    logic [PW-1:0] w_up_pos [1:LEVELS];
    logic [KW-1:0] w_up_key [1:LEVELS];
    logic [KW-1:0] w_fkey [1:LEVELS-1];
    logic [LEVELS-1:1] w_done;

    logic          w_accept;
    logic [KW-1:0] w_key;
    logic [PW-1:0] w_hnew;
    logic [SW-1:0] w_lnew;
    logic [KW-1:0] w_fetch_key;
    logic          w_chain_busy;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_key      = KW'(i_in_data.key_value);
    assign w_hnew     = r_count + PW'(1);

    // level of the new slot: position of the leading one
    always_comb begin
        w_lnew = '0;
        for (int i = 0; i < PW; i++) begin
            if (w_hnew[i]) begin
                w_lnew = SW'(i);
            end
        end
    end

    // only the addressed level drives its fetch key; the rest give zero
    always_comb begin
        w_fetch_key = '0;
        for (int l = 1; l < LEVELS; l++) begin
            w_fetch_key = w_fetch_key | w_fkey[l];
        end
    end

    always_comb begin
        w_chain_busy = |w_done;
        for (int l = 1; l < LEVELS; l++) begin
            w_chain_busy = w_chain_busy || w_tok[l].vld || w_up_vld[l];
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_vld   = r_out_vld && i_out_stall;
        n_t1        = '0;
        n_fetch_vld = 1'b0;
        n_root      = r_root;
        n_err       = r_err;
        n_t1_pos    = r_t1_pos;
        n_t1_tgt    = r_t1_tgt;
        n_t1_sh     = r_t1_sh;
        n_t1_key    = r_t1_key;
        n_fetch_pos = r_fetch_pos;
        n_out       = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.op == OP_INSERT) begin
                        if (r_count == PW'(CAPACITY)) begin
                            // drop the key, report full
                            n_err   = ERR_FULL;
                            n_state = S_DONE;
                        end else if (r_count == '0) begin
                            n_err   = ERR_OK;
                            n_count = w_hnew;
                            n_root  = w_key;
                            n_state = S_DONE;
                        end else begin
                            // settle the root here, carry the smaller key down
                            n_err     = ERR_OK;
                            n_count   = w_hnew;
                            n_root    = (r_root < w_key) ? w_key : r_root;
                            n_t1.vld  = 1'b1;
                            n_t1.kind = KIND_INS;
                            n_t1_pos  = PW'(1);
                            n_t1_tgt  = w_hnew;
                            n_t1_sh   = w_lnew - SW'(1);
                            n_t1_key  = (r_root < w_key) ? r_root : w_key;
                            n_state   = S_WAIT;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_err   = ERR_EMPTY;
                            n_state = S_DONE;
                        end else if (r_count == PW'(1)) begin
                            n_err   = ERR_OK;
                            n_count = '0;
                            n_state = S_DONE;
                        end else begin
                            // read the last key before sifting it down
                            n_err       = ERR_OK;
                            n_count     = r_count - PW'(1);
                            n_fetch_vld = 1'b1;
                            n_fetch_pos = r_count;
                            n_state     = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_root = w_fetch_key;
                if (r_count >= PW'(2)) begin
                    n_t1.vld  = 1'b1;
                    n_t1.kind = KIND_DOWN;
                    n_t1_pos  = PW'(1);
                    n_t1_tgt  = r_count;
                    n_t1_key  = w_fetch_key;
                    n_state   = S_WAIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WAIT: begin
                if (w_up_vld[1]) begin
                    n_root = w_up_key[1];
                end
                if (|w_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out.top_value     = (r_count != '0) ? TOP_W'(r_root) : '0;
                    n_out.top_valid     = (r_count != '0);
                    n_out.element_total = TOTAL_W'(r_count);
                    n_out.error_code    = r_err;
                    n_out_vld           = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_vld   <= 1'b0;
            r_t1        <= '0;
            r_fetch_vld <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_vld   <= n_out_vld;
            r_t1        <= n_t1;
            r_fetch_vld <= n_fetch_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root      <= n_root;
        r_err       <= n_err;
        r_t1_pos    <= n_t1_pos;
        r_t1_tgt    <= n_t1_tgt;
        r_t1_sh     <= n_t1_sh;
        r_t1_key    <= n_t1_key;
        r_fetch_pos <= n_fetch_pos;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // feed the first level from the sequencer; nothing promotes from below the bottom
    assign w_tok[1]          = r_t1;
    assign w_pos[1]          = r_t1_pos;
    assign w_tgt[1]          = r_t1_tgt;
    assign w_sh[1]           = r_t1_sh;
    assign w_tkey[1]         = r_t1_key;
    assign w_up_vld[LEVELS]  = 1'b0;
    assign w_up_pos[LEVELS]  = '0;
    assign w_up_key[LEVELS]  = '0;

    for (genvar l = 1; l < LEVELS; l++) begin : g_level
        if (l < LEVELS - 1) begin : g_mid
            bmh_cell #(
                .LEVEL (l), .LEVELS (LEVELS), .KW (KW), .PW (PW), .SW (SW)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_tok       (w_tok[l]),
                .i_pos       (w_pos[l]),
                .i_tgt       (w_tgt[l]),
                .i_sh        (w_sh[l]),
                .i_key       (w_tkey[l]),
                .o_tok       (w_tok[l+1]),
                .o_pos       (w_pos[l+1]),
                .o_tgt       (w_tgt[l+1]),
                .o_sh        (w_sh[l+1]),
                .o_key       (w_tkey[l+1]),
                .i_up_vld    (w_up_vld[l+1]),
                .i_up_pos    (w_up_pos[l+1]),
                .i_up_key    (w_up_key[l+1]),
                .o_up_vld    (w_up_vld[l]),
                .o_up_pos    (w_up_pos[l]),
                .o_up_key    (w_up_key[l]),
                .i_fetch_vld (r_fetch_vld),
                .i_fetch_pos (r_fetch_pos),
                .o_fetch_key (w_fkey[l]),
                .o_done      (w_done[l])
            );
        end else begin : g_bottom
            bmh_cell #(
                .LEVEL (l), .LEVELS (LEVELS), .KW (KW), .PW (PW), .SW (SW)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_tok       (w_tok[l]),
                .i_pos       (w_pos[l]),
                .i_tgt       (w_tgt[l]),
                .i_sh        (w_sh[l]),
                .i_key       (w_tkey[l]),
                .o_tok       (),
                .o_pos       (),
                .o_tgt       (),
                .o_sh        (),
                .o_key       (),
                .i_up_vld    (w_up_vld[l+1]),
                .i_up_pos    (w_up_pos[l+1]),
                .i_up_key    (w_up_key[l+1]),
                .o_up_vld    (w_up_vld[l]),
                .o_up_pos    (w_up_pos[l]),
                .o_up_key    (w_up_key[l]),
                .i_fetch_vld (r_fetch_vld),
                .i_fetch_pos (r_fetch_pos),
                .o_fetch_key (w_fkey[l]),
                .o_done      (w_done[l])
            );
        end
    end

    // the chain is quiet whenever a new item may be taken
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_chain_busy)
        else $error("level chain active while idle");

    // a token ends at exactly one level
    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_done))
        else $error("more than one level reports completion");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_done) |-> (r_state == S_WAIT))
        else $error("level completion outside the wait state");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= PW'(CAPACITY))
        else $error("element count beyond capacity");

    a_empty_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.error_code == ERR_EMPTY)) |->
        (!o_out_data.top_valid && (o_out_data.top_value == '0)))
        else $error("empty removal reports a key");

endmodule

`default_nettype wire
